[sv/md4_hash_engine_unit_assert.svh]
// Assertion macros for the MD4 engine.
`ifndef MD4_HASH_ENGINE_UNIT_ASSERT_SVH
`define MD4_HASH_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define MD4HE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("md4he check failed");

// next-cycle implication
`define MD4HE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("md4he check failed");

`endif

[sv/md4he_pkg.sv]
`default_nettype none
package md4he_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] bit_count;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out;

    typedef logic [3:0][31:0] t_words;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_PAD,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_COMP,
        ST_OUT
    } t_state;

    localparam logic [2:0] CFG_START_A   = 3'd0;
    localparam logic [2:0] CFG_START_B   = 3'd1;
    localparam logic [2:0] CFG_START_C   = 3'd2;
    localparam logic [2:0] CFG_START_D   = 3'd3;
    localparam logic [2:0] CFG_START_LEN = 3'd4;

    localparam logic [31:0] START_A_RST = 32'h67452301;
    localparam logic [31:0] START_B_RST = 32'hefcdab89;
    localparam logic [31:0] START_C_RST = 32'h98badcfe;
    localparam logic [31:0] START_D_RST = 32'h10325476;

    localparam logic [31:0] K_ROUND1 = 32'h5A827999;
    localparam logic [31:0] K_ROUND2 = 32'h6ED9EBA1;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [3:0] FULL_BITS  = 4'd8;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [5:0] FILL_END   = 6'd63;
    localparam logic [3:0] WORD_LAST  = 4'd15;
    localparam logic [3:0] WORD_LEN_LO = 4'd14;
    localparam logic [3:0] WORD_LEN_HI = 4'd15;
    localparam logic [5:0] STEP_LAST  = 6'd48;
    localparam logic [5:0] COMP_LAST  = 6'd49;
    localparam logic [1:0] IDX_LAST   = 2'd3;

    // message word used by a step
    function automatic logic [3:0] f_widx(input logic [5:0] step);
        logic [3:0] j;
        logic [3:0] res;
        j = step[3:0];
        unique case (step[5:4])
            2'd1:    res = {j[1:0], j[3:2]};
            2'd2:    res = {j[0], j[1], j[2], j[3]};
            default: res = j;
        endcase
        return res;
    endfunction

    // rotate amount of a step
    function automatic logic [4:0] f_rsh(input logic [5:0] step);
        logic [4:0] res;
        unique case ({step[5:4], step[1:0]})
            4'b00_00: res = 5'd3;
            4'b00_01: res = 5'd7;
            4'b00_10: res = 5'd11;
            4'b00_11: res = 5'd19;
            4'b01_00: res = 5'd3;
            4'b01_01: res = 5'd5;
            4'b01_10: res = 5'd9;
            4'b01_11: res = 5'd13;
            4'b10_00: res = 5'd3;
            4'b10_01: res = 5'd9;
            4'b10_10: res = 5'd11;
            4'b10_11: res = 5'd15;
            default:  res = 5'd0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

[sv/md4he_ram.sv]
`default_nettype none
module md4he_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[sv/md4he_step.sv]
`default_nettype none
module md4he_step (
    input  wire md4he_pkg::t_words i_v,
    input  wire logic [31:0]       i_m,
    input  wire logic [5:0]        i_step,
    output logic      [31:0]       o_a
);
    import md4he_pkg::*;

    logic [31:0] b, c, d, f, sum;
    logic [63:0] dbl;

    always_comb begin
        b = i_v[1];
        c = i_v[2];
        d = i_v[3];
        unique case (i_step[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = ((b & c) | (b & d) | (c & d)) + K_ROUND1;
            default: f = (b ^ c ^ d) + K_ROUND2;
        endcase
        sum = i_v[0] + f + i_m;
        dbl = {sum, sum} << f_rsh(i_step);
        o_a = dbl[63:32];
    end

endmodule
`default_nettype wire

[sv/md4_hash_engine_unit.sv]
// MD4 engine, one message byte per input beat.
// A beat that fills a 64-byte block starts the 48 steps of the shared round unit
// (one step per cycle, message words from a 16x32 RAM).
// A last beat adds the marker, padding, length and compress states, plus another block
// when an extra one is needed, then 4 digest beats, one per cycle when taken.
// Reset is synchronous, active low; start registers take the standard MD4 values.
`default_nettype none
`include "md4_hash_engine_unit_assert.svh"
module md4_hash_engine_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire md4he_pkg::t_in   i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output md4he_pkg::t_out       o_out,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [63:0]      i_cfg_data
);
    import md4he_pkg::*;

    t_state      r_state, n_state;
    t_words      r_start;
    logic [63:0] r_start_len;
    t_words      r_chain;
    t_words      r_v;
    logic [63:0] r_total;
    logic [5:0]  r_fill;
    logic [31:0] r_word;
    logic [5:0]  r_k;
    logic [1:0]  r_oidx;
    logic        r_active, r_last, r_marked, r_final;

    logic        in_acc, in_full, in_part, in_take, push;
    logic [3:0]  n_cnt, in_sh;
    logic [7:0]  in_keep, in_byte;
    logic [5:0]  base_fill;
    logic [31:0] base_word;
    logic [63:0] base_total;
    logic [5:0]  ins_fill;
    logic [31:0] ins_word, ins_merged;
    logic [7:0]  ins_byte;
    logic        out_acc;

    logic        ram_we;
    logic [3:0]  ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata;
    logic [31:0] step_a;
    logic [5:0]  step_idx;

    md4he_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign step_idx = r_k - 6'd1;

    md4he_step u_step (
        .i_v    (r_v),
        .i_m    (ram_rdata),
        .i_step (step_idx),
        .o_a    (step_a)
    );

    // input decode and byte insertion
    always_comb begin
        in_acc     = i_in_valid && o_in_ready;
        n_cnt      = (i_in.bit_count > FULL_BITS) ? FULL_BITS : i_in.bit_count;
        in_full    = (n_cnt == FULL_BITS);
        in_part    = (n_cnt != 4'd0) && !in_full;
        in_take    = in_acc && (in_full || i_in.last_byte);
        push       = in_take && (n_cnt != 4'd0);
        in_sh      = FULL_BITS - n_cnt;
        in_keep    = 8'(8'hFF << in_sh);
        in_byte    = in_full ? i_in.data_byte
                             : ((i_in.data_byte & in_keep) | 8'(PAD_MARKER >> n_cnt));
        base_fill  = r_active ? r_fill : 6'd0;
        base_word  = r_active ? r_word : 32'd0;
        base_total = r_active ? r_total : r_start_len;
        if (r_state == ST_MARK) begin
            ins_fill = r_fill;
            ins_word = r_word;
            ins_byte = PAD_MARKER;
        end else begin
            ins_fill = base_fill;
            ins_word = base_word;
            ins_byte = in_byte;
        end
        ins_merged = ins_word | (32'(ins_byte) << {ins_fill[1:0], 3'b000});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (push && ins_fill == FILL_END) begin
                        n_state = ST_COMP;
                    end else if (i_in.last_byte) begin
                        n_state = in_part ? ST_PAD : ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                n_state = (r_fill == FILL_END) ? ST_COMP : ST_PAD;
            end
            ST_PAD: begin
                if (r_fill == FILL_LEN) begin
                    n_state = ST_LEN_LO;
                end else if (r_fill[5:2] == WORD_LAST) begin
                    n_state = ST_COMP;
                end
            end
            ST_LEN_LO: n_state = ST_LEN_HI;
            ST_LEN_HI: n_state = ST_COMP;
            ST_COMP: begin
                if (r_k == COMP_LAST) begin
                    if (r_final) begin
                        n_state = ST_OUT;
                    end else if (r_last) begin
                        n_state = r_marked ? ST_PAD : ST_MARK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (out_acc && r_oidx == IDX_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and buffer port
    always_comb begin
        o_in_ready        = (r_state == ST_IDLE);
        o_out_valid       = (r_state == ST_OUT);
        out_acc           = o_out_valid && i_out_ready;
        o_out.digest_word = r_chain[r_oidx];
        o_out.word_index  = r_oidx;
        o_out.last_word   = (r_oidx == IDX_LAST);
        ram_raddr         = f_widx(r_k);
        ram_we            = 1'b0;
        ram_waddr         = ins_fill[5:2];
        ram_wdata         = ins_merged;
        unique case (r_state)
            ST_IDLE: ram_we = push && (ins_fill[1:0] == 2'd3);
            ST_MARK: ram_we = (r_fill[1:0] == 2'd3);
            ST_PAD: begin
                ram_we    = (r_fill != FILL_LEN);
                ram_waddr = r_fill[5:2];
                ram_wdata = r_word;
            end
            ST_LEN_LO: begin
                ram_we    = 1'b1;
                ram_waddr = WORD_LEN_LO;
                ram_wdata = r_total[31:0];
            end
            ST_LEN_HI: begin
                ram_we    = 1'b1;
                ram_waddr = WORD_LEN_HI;
                ram_wdata = r_total[63:32];
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= {START_D_RST, START_C_RST, START_B_RST, START_A_RST};
            r_start_len <= 64'd0;
            r_fill      <= 6'd0;
            r_word      <= 32'd0;
            r_k         <= 6'd0;
            r_oidx      <= 2'd0;
            r_active    <= 1'b0;
            r_last      <= 1'b0;
            r_marked    <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_START_A:   r_start[0]  <= i_cfg_data[31:0];
                    CFG_START_B:   r_start[1]  <= i_cfg_data[31:0];
                    CFG_START_C:   r_start[2]  <= i_cfg_data[31:0];
                    CFG_START_D:   r_start[3]  <= i_cfg_data[31:0];
                    CFG_START_LEN: r_start_len <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        if (!r_active) begin
                            r_chain <= r_start;
                        end
                        r_active <= 1'b1;
                        r_total  <= base_total + {60'd0, n_cnt};
                        r_last   <= i_in.last_byte;
                        r_marked <= in_part;
                        r_final  <= 1'b0;
                        if (push) begin
                            r_fill <= ins_fill + 6'd1;
                            r_word <= (ins_fill[1:0] == 2'd3) ? 32'd0 : ins_merged;
                        end else begin
                            r_fill <= base_fill;
                            r_word <= base_word;
                        end
                    end
                end
                ST_MARK: begin
                    r_fill   <= r_fill + 6'd1;
                    r_word   <= (r_fill[1:0] == 2'd3) ? 32'd0 : ins_merged;
                    r_marked <= 1'b1;
                end
                ST_PAD: begin
                    if (r_fill != FILL_LEN) begin
                        r_fill <= {r_fill[5:2] + 4'd1, 2'b00};
                        r_word <= 32'd0;
                    end
                end
                ST_LEN_HI: r_final <= 1'b1;
                ST_COMP: begin
                    if (r_k == 6'd0) begin
                        r_v <= r_chain;
                        r_k <= r_k + 6'd1;
                    end else if (r_k <= STEP_LAST) begin
                        r_v <= {r_v[2], r_v[1], step_a, r_v[3]};
                        r_k <= r_k + 6'd1;
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            r_chain[i] <= r_chain[i] + r_v[i];
                        end
                        r_k <= 6'd0;
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == IDX_LAST) begin
                            r_active <= 1'b0;
                            r_fill   <= 6'd0;
                            r_final  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `MD4HE_ASSERT_NOW(a_no_ready_in_out, o_out_valid, !o_in_ready)
    `MD4HE_ASSERT_NOW(a_no_write_in_comp, r_state == ST_COMP, !ram_we)
    `MD4HE_ASSERT_NXT(a_idle_after_digest, out_acc && o_out.last_word, o_in_ready && !r_active)
    `MD4HE_ASSERT_NXT(a_index_steps, out_acc && !o_out.last_word, o_out_valid && (o_out.word_index == $past(o_out.word_index) + 2'd1))

endmodule
`default_nettype wire
